// ----- rtl/ltfc_pkg.sv -----
// Package for the link test frame checker.
// Holds the request/result payload types, the status and opcode codes and the frame constants.
// No dependencies.
package ltfc_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int CNT_W = 32;

	localparam logic [7:0] SYNC_FIRST_RST = 8'hA5;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_SYNC     = 2'd1,
		ST_CHECKSUM = 2'd2
	} status_t;

	typedef enum logic {
		CFG_SYNC_FIRST  = 1'b0,
		CFG_SYNC_SECOND = 1'b1
	} cfg_index_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		status_t        status;
		logic [7:0]     frame_id;
		logic           dropped;
		logic           payload_bad;
		logic [CNT_W-1:0] frame_count;
		logic [CNT_W-1:0] sync_errors;
		logic [CNT_W-1:0] checksum_errors;
		logic [CNT_W-1:0] drop_errors;
		logic [CNT_W-1:0] payload_errors;
	} rsp_t;

	// completed-frame summary from the framer to the statistics unit
	typedef struct packed {
		logic       done;
		logic       sync_ok;
		logic       sum_ok;
		logic [7:0] id;
		logic       pay_bad;
		// hunt found both sync bytes in this request
		logic       resync;
	} frame_t;

endpackage

// ----- rtl/ltfc_framer.sv -----
// Byte framer: tracks position, sync hunt, running XOR and payload pattern.
// Reports each completed frame as a frame_t summary. Depends on ltfc_pkg.
module ltfc_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic [7:0]        sync_first,
	input  logic [7:0]        sync_second,
	output ltfc_pkg::frame_t  frame
);
	import ltfc_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q, pos_d;
	logic             hunt_q, hunt_d;
	logic [7:0]       prev_q;
	logic [7:0]       head0_q, head1_q, head2_q;
	logic [7:0]       head0_d, head1_d, head2_d;
	logic [7:0]       xor_q, xor_d, xor_acc;
	logic             mism_q, mism_d, mism_acc;
	logic [7:0]       pattern;
	logic             last;
	logic             sync_hit;

	assign pattern  = head2_q + {{(8 - POS_W){1'b0}}, pos_q} - 8'd4;
	assign last     = (pos_q == LAST_POS);
	assign sync_hit = en && hunt_q && (prev_q == sync_first) && (data_byte == sync_second);

	always_comb begin
		xor_acc  = (pos_q == '0) ? data_byte : (xor_q ^ data_byte);
		mism_acc = (pos_q == '0) ? 1'b0 : mism_q;
		if (pos_q >= POS_W'(4) && data_byte != pattern) begin
			mism_acc = 1'b1;
		end
	end

	always_comb begin
		frame.done    = en && !hunt_q && last;
		frame.sync_ok = (head0_q == sync_first) && (head1_q == sync_second);
		frame.sum_ok  = (xor_acc == 8'd0);
		frame.id      = head2_q;
		frame.pay_bad = mism_acc;
		frame.resync  = sync_hit;
	end

	always_comb begin
		pos_d   = pos_q;
		hunt_d  = hunt_q;
		head0_d = head0_q;
		head1_d = head1_q;
		head2_d = head2_q;
		xor_d   = xor_q;
		mism_d  = mism_q;
		if (en) begin
			if (hunt_q) begin
				// resume at byte 2 once both sync bytes are seen in a row
				if (sync_hit) begin
					head0_d = sync_first;
					head1_d = sync_second;
					xor_d   = sync_first ^ sync_second;
					mism_d  = 1'b0;
					pos_d   = POS_W'(2);
					hunt_d  = 1'b0;
				end
			end else begin
				xor_d  = xor_acc;
				mism_d = mism_acc;
				case (pos_q)
					POS_W'(0): head0_d = data_byte;
					POS_W'(1): head1_d = data_byte;
					POS_W'(2): head2_d = data_byte;
					default:   head2_d = head2_q;
				endcase
				if (last) begin
					pos_d  = '0;
					hunt_d = !(frame.sync_ok && frame.sum_ok);
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hunt_q  <= 1'b0;
			prev_q  <= '0;
			head0_q <= '0;
			head1_q <= '0;
			head2_q <= '0;
			xor_q   <= '0;
			mism_q  <= 1'b0;
		end else begin
			pos_q   <= pos_d;
			hunt_q  <= hunt_d;
			head0_q <= head0_d;
			head1_q <= head1_d;
			head2_q <= head2_d;
			xor_q   <= xor_d;
			mism_q  <= mism_d;
			if (en) begin
				prev_q <= data_byte;
			end
		end
	end

endmodule

// ----- rtl/ltfc_stats.sv -----
// Statistics unit: event counters, expected sequence id and continuity skip.
// Builds the result for each completed frame. Depends on ltfc_pkg.
module ltfc_stats (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  ltfc_pkg::frame_t frame,
	output ltfc_pkg::rsp_t   rsp
);
	import ltfc_pkg::*;

	logic [CNT_W-1:0] frames_q, sync_q, sum_q, drop_q, pay_q;
	logic [CNT_W-1:0] frames_d, sync_d, sum_d, drop_d, pay_d;
	logic [7:0]       exp_q, exp_d;
	logic             skip_q, skip_d;
	logic             drop;
	logic             pbad;
	status_t          status;

	always_comb begin
		frames_d = frames_q;
		sync_d   = sync_q;
		sum_d    = sum_q;
		drop_d   = drop_q;
		pay_d    = pay_q;
		exp_d    = exp_q;
		skip_d   = skip_q;
		drop     = 1'b0;
		pbad     = 1'b0;
		status   = ST_GOOD;
		if (clr) begin
			frames_d = '0;
			sync_d   = '0;
			sum_d    = '0;
			drop_d   = '0;
			pay_d    = '0;
			exp_d    = '0;
		end else if (frame.done) begin
			frames_d = frames_q + CNT_W'(1);
			if (!frame.sync_ok) begin
				status = ST_SYNC;
				sync_d = sync_q + CNT_W'(1);
			end else if (!frame.sum_ok) begin
				status = ST_CHECKSUM;
				sum_d  = sum_q + CNT_W'(1);
			end else begin
				// first good frame after a resync sets the id without a drop check
				if (skip_q) begin
					skip_d = 1'b0;
				end else if (frame.id != exp_q) begin
					drop   = 1'b1;
					drop_d = drop_q + CNT_W'(1);
				end
				exp_d = frame.id + 8'd1;
				if (frame.pay_bad) begin
					pbad  = 1'b1;
					pay_d = pay_q + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		rsp.status          = status;
		rsp.frame_id        = frame.id;
		rsp.dropped         = drop;
		rsp.payload_bad     = pbad;
		rsp.frame_count     = frames_d;
		rsp.sync_errors     = sync_d;
		rsp.checksum_errors = sum_d;
		rsp.drop_errors     = drop_d;
		rsp.payload_errors  = pay_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			sync_q   <= '0;
			sum_q    <= '0;
			drop_q   <= '0;
			pay_q    <= '0;
			exp_q    <= '0;
			skip_q   <= 1'b0;
		end else begin
			frames_q <= frames_d;
			sync_q   <= sync_d;
			sum_q    <= sum_d;
			drop_q   <= drop_d;
			pay_q    <= pay_d;
			exp_q    <= exp_d;
			// a resync arms the continuity skip
			skip_q   <= skip_d | frame.resync;
		end
	end

endmodule

// ----- rtl/link_test_frame_checker.sv -----
// Top level of the link test frame checker: config registers, framer, statistics, result buffer.
// Depends on ltfc_pkg, ltfc_framer and ltfc_stats.
//
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_stall     ltfc_pkg::req_t (opcode, data_byte)
//   rsp      out  rsp_valid / rsp_stall     ltfc_pkg::rsp_t (status, id, flags, counters)
//   cfg      in   cfg_we                    cfg_index, cfg_data
//
// One request per cycle while req_stall is low; a completed frame's result is registered.
// Framing, hunt and statistics update in the cycle the request is taken.
// Results sit in an output register backed by one skid entry; req_stall rises only while
// both hold a result. Reset clears all control state and counters; sync bytes return to A5/5A.
module link_test_frame_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ltfc_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output ltfc_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [7:0]       cfg_data
);
	import ltfc_pkg::*;

	logic [7:0] sync_first_q, sync_second_q;
	logic       req_fire, data_en, clr;
	logic       rsp_take;
	logic       skid_valid_q;
	rsp_t       skid_q;
	rsp_t       res;
	frame_t     frame;

	assign req_stall = skid_valid_q;
	assign req_fire  = req_valid && !req_stall;
	assign data_en   = req_fire && (req.opcode == OP_DATA);
	assign clr       = req_fire && (req.opcode == OP_CLEAR);
	assign rsp_take  = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default:         sync_first_q  <= sync_first_q;
			endcase
		end
	end

	ltfc_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (data_en),
		.data_byte   (req.data_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.frame       (frame)
	);

	ltfc_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.frame  (frame),
		.rsp    (res)
	);

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (rsp_take) begin
			rsp_valid    <= skid_valid_q | frame.done;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid) begin
			rsp_valid <= frame.done;
		end else if (frame.done) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rsp <= skid_valid_q ? skid_q : res;
		end else if (!rsp_valid) begin
			rsp <= res;
		end else if (frame.done) begin
			skid_q <= res;
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid)
		else $error("skid entry held without an output result");

	a_no_result_into_full: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |-> !skid_valid_q)
		else $error("frame completed while result buffer full");

	a_result_shows: assert property (@(posedge clk) disable iff (!arst_n)
		frame.done |=> rsp_valid)
		else $error("completed frame did not reach the output");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(clr && !rsp_valid) |=> (!rsp_valid || rsp.frame_count == CNT_W'(1)))
		else $error("counters not cleared");

endmodule

// ----- dv/tb_link_test_frame_checker.sv -----
// Testbench for link_test_frame_checker: directed and random test frames checked against a
// cycle-free predictor of framing, hunt and statistics. Depends on ltfc_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_link_test_frame_checker;
	import ltfc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		FLAW_NONE,
		FLAW_PAYLOAD,
		FLAW_CHECKSUM,
		FLAW_SYNC
	} frame_flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	bit gaps_enabled = 1'b1;
	int failures = 0;
	int requests_sent = 0;
	int cycles = 0;

	// predictor state
	logic [7:0]  sync_a = SYNC_FIRST_RST;
	logic [7:0]  sync_b = SYNC_SECOND_RST;
	int          frame_pos = 0;
	bit          hunting_sync = 1'b0;
	logic [7:0]  prev_byte = '0;
	logic [7:0]  head [3] = '{default: '0};
	logic [7:0]  xor_acc = '0;
	bit          pay_mismatch = 1'b0;
	logic [7:0]  next_id = '0;
	bit          skip_id_check = 1'b0;
	logic [31:0] frames_seen = '0;
	logic [31:0] sync_fails = '0;
	logic [31:0] sum_fails = '0;
	logic [31:0] drops_seen = '0;
	logic [31:0] payload_fails = '0;

	rsp_t frame_reports [$];

	link_test_frame_checker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_stall <= gaps_enabled && ($urandom_range(99) < 15);
	end

	function automatic void predict_request(input req_t r);
		logic [7:0] b;
		rsp_t report;
		if (r.opcode == OP_CLEAR) begin
			frames_seen = '0;
			sync_fails = '0;
			sum_fails = '0;
			drops_seen = '0;
			payload_fails = '0;
			next_id = '0;
			return;
		end
		b = r.data_byte;
		if (hunting_sync) begin
			if (prev_byte == sync_a && b == sync_b) begin
				head[0] = sync_a;
				head[1] = sync_b;
				xor_acc = sync_a ^ sync_b;
				pay_mismatch = 1'b0;
				frame_pos = 2;
				hunting_sync = 1'b0;
				skip_id_check = 1'b1;
			end
			prev_byte = b;
			return;
		end
		if (frame_pos == 0) begin
			xor_acc = b;
			pay_mismatch = 1'b0;
		end else begin
			xor_acc = xor_acc ^ b;
		end
		if (frame_pos < 3)
			head[frame_pos] = b;
		else if (frame_pos >= 4 && b != 8'(head[2] + 8'(frame_pos - 4)))
			pay_mismatch = 1'b1;
		prev_byte = b;
		frame_pos++;
		if (frame_pos < FRAME_BYTES)
			return;

		frame_pos = 0;
		report = '0;
		report.frame_id = head[2];
		frames_seen++;
		if (head[0] != sync_a || head[1] != sync_b) begin
			sync_fails++;
			report.status = ST_SYNC;
			hunting_sync = 1'b1;
		end else if (xor_acc != 8'h00) begin
			sum_fails++;
			report.status = ST_CHECKSUM;
			hunting_sync = 1'b1;
		end else begin
			report.status = ST_GOOD;
			if (skip_id_check) begin
				skip_id_check = 1'b0;
			end else if (head[2] != next_id) begin
				report.dropped = 1'b1;
				drops_seen++;
			end
			next_id = head[2] + 8'd1;
			if (pay_mismatch) begin
				report.payload_bad = 1'b1;
				payload_fails++;
			end
		end
		report.frame_count = frames_seen;
		report.sync_errors = sync_fails;
		report.checksum_errors = sum_fails;
		report.drop_errors = drops_seen;
		report.payload_errors = payload_fails;
		frame_reports.push_back(report);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (frame_reports.size() == 0) begin
				$error("unexpected result: frame_id %0d status %0d", rsp.frame_id, rsp.status);
				failures++;
			end else begin
				want = frame_reports.pop_front();
				compare_field("status", want.status, rsp.status);
				compare_field("frame_id", want.frame_id, rsp.frame_id);
				compare_field("dropped", want.dropped, rsp.dropped);
				compare_field("payload_bad", want.payload_bad, rsp.payload_bad);
				compare_field("frame_count", want.frame_count, rsp.frame_count);
				compare_field("sync_errors", want.sync_errors, rsp.sync_errors);
				compare_field("checksum_errors", want.checksum_errors, rsp.checksum_errors);
				compare_field("drop_errors", want.drop_errors, rsp.drop_errors);
				compare_field("payload_errors", want.payload_errors, rsp.payload_errors);
			end
		end
	end

	// Called at a rising edge; returns at the edge that takes the request.
	task automatic send_request(input opcode_t op, input logic [7:0] b);
		req_t r;
		r.opcode = op;
		r.data_byte = b;
		if (gaps_enabled && $urandom_range(99) < 15) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		predict_request(r);
		requests_sent++;
	endtask

	// Build a frame for the present sync setting and send it from the current byte position.
	task automatic send_frame(input logic [7:0] id, input frame_flaw_t flaw);
		logic [7:0] frame_img [FRAME_BYTES];
		logic [7:0] flip;
		int k;
		int first;
		frame_img[0] = sync_a;
		frame_img[1] = sync_b;
		frame_img[2] = id;
		frame_img[3] = '0;
		for (k = 4; k < FRAME_BYTES; k++)
			frame_img[k] = id + 8'(k - 4);
		for (k = 0; k < FRAME_BYTES; k++)
			if (k != 3)
				frame_img[3] = frame_img[3] ^ frame_img[k];
		flip = 8'($urandom_range(1, 255));
		case (flaw)
			FLAW_PAYLOAD: begin
				// keep the checksum right so the frame still passes as good
				k = $urandom_range(4, FRAME_BYTES - 1);
				frame_img[k] = frame_img[k] ^ flip;
				frame_img[3] = frame_img[3] ^ flip;
			end
			FLAW_CHECKSUM: begin
				k = $urandom_range(2, FRAME_BYTES - 1);
				frame_img[k] = frame_img[k] ^ flip;
			end
			FLAW_SYNC: begin
				k = $urandom_range(0, 1);
				frame_img[k] = frame_img[k] ^ flip;
			end
			default: begin
			end
		endcase
		first = frame_pos;
		for (k = first; k < FRAME_BYTES; k++)
			send_request(OP_DATA, frame_img[k]);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (frame_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync_pair(input logic [7:0] first, input logic [7:0] second);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= first;
		@(posedge clk);
		sync_a = first;
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data <= second;
		@(posedge clk);
		sync_b = second;
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_frames();
		// id FF wraps the payload through 00; the expected id is still 0, so this is a drop
		send_frame(8'hFF, FLAW_NONE);
		send_request(OP_CLEAR, 8'hFF);
		// last payload byte equals sync_first, so one sync_second byte ends the hunt
		send_frame(sync_a - 8'd7, FLAW_SYNC);
		send_request(OP_DATA, sync_b);
	endtask

	task automatic test_random_traffic(input int items);
		int start;
		int kind;
		frame_flaw_t flaw;
		logic [7:0] id;
		start = requests_sent;
		while (requests_sent - start < items) begin
			if (hunting_sync) begin
				if ($urandom_range(9) == 0) begin
					send_request(OP_DATA, sync_b);
				end else begin
					repeat ($urandom_range(0, 3)) send_request(OP_DATA, 8'($urandom));
					send_request(OP_DATA, sync_a);
					send_request(OP_DATA, sync_b);
				end
				continue;
			end
			kind = $urandom_range(99);
			if (kind < 4) begin
				send_request(OP_CLEAR, 8'($urandom));
				continue;
			end
			if (kind < 9) begin
				repeat ($urandom_range(1, 3)) send_request(OP_DATA, 8'($urandom));
				continue;
			end
			id = next_id;
			if (kind < 60)
				flaw = FLAW_NONE;
			else if (kind < 70)
				flaw = FLAW_PAYLOAD;
			else if (kind < 80)
				flaw = FLAW_CHECKSUM;
			else if (kind < 90)
				flaw = FLAW_SYNC;
			else begin
				flaw = FLAW_NONE;
				id = 8'($urandom);
			end
			send_frame(id, flaw);
		end
	endtask

	task automatic test_sync_setting(input logic [7:0] first, input logic [7:0] second,
			input int items);
		drain_results();
		write_sync_pair(first, second);
		test_random_traffic(items);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();

		gaps_enabled = 1'b1;
		test_random_traffic(300);
		gaps_enabled = 1'b0;
		test_random_traffic(150);
		gaps_enabled = 1'b1;

		test_sync_setting(8'h00, 8'hFF, 110);
		test_sync_setting(8'hFF, 8'h00, 110);
		test_sync_setting(8'($urandom), 8'($urandom), 90);
		test_sync_setting(SYNC_FIRST_RST, SYNC_SECOND_RST, 90);

		drain_results();
		if (failures == 0 && frame_reports.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
